### src/tftp_rts_pkg.sv
// shared types, codes and constants for the tftp read transfer sequencer
`default_nettype none
package tftp_rts_pkg;

    localparam int CMD_W    = 2;
    localparam int OP_W     = 16;
    localparam int BLK_W    = 16;
    localparam int DLEN_W   = 11;
    localparam int PLEN_W   = 10;
    localparam int STATUS_W = 2;
    localparam int BYTES_W  = 32;
    localparam int PHASE_W  = 2;

    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DGRAM   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [OP_W-1:0] OPCODE_DATA  = 16'd3;
    localparam logic [OP_W-1:0] OPCODE_ERROR = 16'd5;

    localparam logic [DLEN_W-1:0] HDR_BYTES    = 11'd4;
    localparam logic [DLEN_W-1:0] RX_BUF_BYTES = 11'd1024;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RECV  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

    localparam logic [PLEN_W-1:0] CHUNK_SIZE_RESET = 10'd512;
    localparam logic [BLK_W-1:0]  FIRST_BLOCK      = 16'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [OP_W-1:0]   opcode;
        logic [BLK_W-1:0]  block_number;
        logic [DLEN_W-1:0] datagram_length;
    } t_item;

    typedef struct packed {
        logic                send_request;
        logic                send_ack;
        logic [BLK_W-1:0]    ack_block;
        logic                store_payload;
        logic [BYTES_W-1:0]  store_offset;
        logic [PLEN_W-1:0]   payload_length;
        logic [STATUS_W-1:0] status;
        logic [BYTES_W-1:0]  total_length;
    } t_result;

endpackage
`default_nettype wire

### src/tftp_rts_in_stage.sv
// input register stage holding one accepted transaction
`default_nettype none
module tftp_rts_in_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  tftp_rts_pkg::t_item  i_item,
    input  wire                  i_adv,
    output logic                 o_stall,
    output logic                 o_vld,
    output tftp_rts_pkg::t_item  o_item
);
    import tftp_rts_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign o_stall = r_vld & ~i_adv;
    assign o_vld   = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

### src/tftp_rts_seq.sv
// transfer state registers and per-transaction header check and update
`default_nettype none
module tftp_rts_seq (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_fire,
    input  tftp_rts_pkg::t_item                  i_item,
    input  wire                                  i_cfg_we,
    input  wire [tftp_rts_pkg::PLEN_W-1:0]       i_cfg_data,
    output tftp_rts_pkg::t_result                o_res
);
    import tftp_rts_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BLK_W-1:0]   r_exp_block, n_exp_block;
    logic [BYTES_W-1:0] r_rx_bytes, n_rx_bytes;
    logic [PLEN_W-1:0]  r_chunk_size;

    logic              busy;
    logic [DLEN_W-1:0] dlen;
    logic [DLEN_W-1:0] pay_full;
    logic [PLEN_W-1:0] pay;
    logic              bad;
    logic              blk_match;

    assign busy      = (r_phase == PH_FIRST) || (r_phase == PH_RECV);
    assign dlen      = (i_item.datagram_length > RX_BUF_BYTES) ? RX_BUF_BYTES
                                                               : i_item.datagram_length;
    assign pay_full  = dlen - HDR_BYTES;
    assign pay       = pay_full[PLEN_W-1:0];
    assign blk_match = (i_item.block_number == r_exp_block);
    assign bad       = (dlen < HDR_BYTES) || (i_item.opcode == OPCODE_ERROR) ||
                       (i_item.opcode != OPCODE_DATA) ||
                       ((r_phase == PH_FIRST) && !blk_match);

    always_comb begin
        n_phase     = r_phase;
        n_exp_block = r_exp_block;
        n_rx_bytes  = r_rx_bytes;
        o_res       = '0;
        case (i_item.cmd)
            CMD_START: begin
                n_phase            = PH_FIRST;
                n_exp_block        = FIRST_BLOCK;
                n_rx_bytes         = '0;
                o_res.send_request = 1'b1;
            end
            CMD_DGRAM: begin
                if (busy) begin
                    if (bad) begin
                        o_res.status = ST_BAD;
                        n_phase      = PH_IDLE;
                    end else begin
                        o_res.send_ack  = 1'b1;
                        o_res.ack_block = i_item.block_number;
                        if (blk_match) begin
                            o_res.store_payload  = 1'b1;
                            o_res.store_offset   = r_rx_bytes;
                            o_res.payload_length = pay;
                            n_rx_bytes = r_rx_bytes + {{(BYTES_W-PLEN_W){1'b0}}, pay};
                            if (pay < r_chunk_size) begin
                                o_res.status = ST_DONE;
                                n_phase      = PH_IDLE;
                            end else begin
                                n_exp_block = r_exp_block + FIRST_BLOCK;
                                n_phase     = PH_RECV;
                            end
                        end
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (busy) begin
                    if (r_phase == PH_FIRST) begin
                        o_res.send_request = 1'b1;
                    end else begin
                        o_res.status = ST_TIMEOUT;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
        o_res.total_length = n_rx_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_exp_block  <= FIRST_BLOCK;
            r_rx_bytes   <= '0;
            r_chunk_size <= CHUNK_SIZE_RESET;
        end else begin
            if (i_fire) begin
                r_phase     <= n_phase;
                r_exp_block <= n_exp_block;
                r_rx_bytes  <= n_rx_bytes;
            end
            if (i_cfg_we) begin
                r_chunk_size <= i_cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

### src/tftp_rts_out_stage.sv
// result register stage feeding the output channel
`default_nettype none
module tftp_rts_out_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  tftp_rts_pkg::t_result  i_res,
    input  wire                    i_stall,
    output logic                   o_free,
    output logic                   o_valid,
    output tftp_rts_pkg::t_result  o_res
);
    import tftp_rts_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free  = ~r_vld | ~i_stall;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

### src/tftp_read_transfer_sequencer_core.sv
// top level of the tftp read transfer sequencer
// an input transaction passes the input register, then the result register, to become a result transaction
// throughput: one transaction per cycle, limited only by output stall
// reset: synchronous active low; phase idle, expected block 1, byte total 0, chunk size 512
// configuration is always ready and takes effect on the next transaction
`default_nettype none
module tftp_read_transfer_sequencer_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire [tftp_rts_pkg::CMD_W-1:0]         i_cmd,
    input  wire [tftp_rts_pkg::OP_W-1:0]          i_opcode,
    input  wire [tftp_rts_pkg::BLK_W-1:0]         i_block_number,
    input  wire [tftp_rts_pkg::DLEN_W-1:0]        i_datagram_length,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [tftp_rts_pkg::PLEN_W-1:0]        i_cfg_data,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic                                  o_send_request,
    output logic                                  o_send_ack,
    output logic [tftp_rts_pkg::BLK_W-1:0]        o_ack_block,
    output logic                                  o_store_payload,
    output logic [tftp_rts_pkg::BYTES_W-1:0]      o_store_offset,
    output logic [tftp_rts_pkg::PLEN_W-1:0]       o_payload_length,
    output logic [tftp_rts_pkg::STATUS_W-1:0]     o_status,
    output logic [tftp_rts_pkg::BYTES_W-1:0]      o_total_length
);
    import tftp_rts_pkg::*;

    t_item   in_item;
    t_item   stg_item;
    t_result seq_res;
    t_result out_res;
    logic    stg_vld;
    logic    out_free;
    logic    adv;

    assign in_item.cmd             = i_cmd;
    assign in_item.opcode          = i_opcode;
    assign in_item.block_number    = i_block_number;
    assign in_item.datagram_length = i_datagram_length;

    assign adv         = stg_vld & out_free;
    assign o_cfg_ready = 1'b1;

    tftp_rts_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_adv   (adv),
        .o_stall (o_stall),
        .o_vld   (stg_vld),
        .o_item  (stg_item)
    );

    tftp_rts_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (adv),
        .i_item     (stg_item),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_res      (seq_res)
    );

    tftp_rts_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (seq_res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_send_request   = out_res.send_request;
    assign o_send_ack       = out_res.send_ack;
    assign o_ack_block      = out_res.ack_block;
    assign o_store_payload  = out_res.store_payload;
    assign o_store_offset   = out_res.store_offset;
    assign o_payload_length = out_res.payload_length;
    assign o_status         = out_res.status;
    assign o_total_length   = out_res.total_length;

    // input side stalls only when both stages hold a transaction
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result stage can drain");

    a_done_stores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DONE)) |-> (o_store_payload && o_send_ack))
        else $error("done without a stored payload");

    a_store_acks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_store_payload) |-> (o_send_ack && (o_status == ST_BUSY ||
                                                         o_status == ST_DONE)))
        else $error("stored payload without acknowledgement");

    a_request_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_request) |-> (!o_send_ack && (o_status == ST_BUSY)))
        else $error("request mixed with other actions");

endmodule
`default_nettype wire
